// ----- sv/ckat_pkg.sv -----
// ----------------------------------------------------------------------------
// ckat_pkg
// Shared types and constants for the client keepalive aging table.
// ----------------------------------------------------------------------------
package ckat_pkg;

  localparam int IP_W      = 32;
  localparam int AGE_W     = 18;
  localparam int CFG_W     = 16;
  localparam int EVICT_W   = 5;
  localparam int CFG_ADDR_W = 1;

  // register indexes on the config port
  localparam logic [CFG_ADDR_W-1:0] REG_AGE_INTERVAL = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_AGE_TIMEOUT  = 1'd1;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_TICK   = 2'd2,
    OP_DRAIN  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // one word of the entry memory
  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [AGE_W-1:0] age;
  } entry_t;

  // one result beat
  typedef struct packed {
    logic               last;
    logic [EVICT_W-1:0] evicted_count;
    logic [IP_W-1:0]    drained_ip;
    logic               table_full;
    logic               done_flag;
  } res_t;

endpackage

// ----- sv/ckat_entry_ram.sv -----
// ----------------------------------------------------------------------------
// ckat_entry_ram
// Simple dual-port entry memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ckat_entry_ram #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output ckat_pkg::entry_t     rd_data,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  ckat_pkg::entry_t     wr_data
);
  import ckat_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while rd_en is low, so the scan can stall on it
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/ckat_out_reg.sv -----
// ----------------------------------------------------------------------------
// ckat_out_reg
// Output register for result beats; frees the engine from downstream stalls.
// ----------------------------------------------------------------------------
module ckat_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ckat_pkg::res_t   push_res,
  output logic             can_take,
  output logic             m_valid,
  input  logic             m_ready,
  output ckat_pkg::res_t   m_res
);
  import ckat_pkg::*;

  assign can_take = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (push) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      m_res <= push_res;
    end
  end

endmodule

// ----- sv/ckat_engine.sv -----
// ----------------------------------------------------------------------------
// ckat_engine
// Operation sequencer: scans the entry memory slot by slot, keeps the valid
// bits and builds the result beats.
// ----------------------------------------------------------------------------
module ckat_engine #(
  parameter int TABLE_SLOTS = 16,
  parameter int SLOT_W      = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ckat_pkg::op_t                  in_op,
  input  logic [ckat_pkg::IP_W-1:0]      in_ip,
  input  logic [ckat_pkg::CFG_W-1:0]     age_interval,
  input  logic [ckat_pkg::CFG_W-1:0]     age_timeout,
  output logic                           ram_rd_en,
  output logic [SLOT_W-1:0]              ram_rd_addr,
  input  ckat_pkg::entry_t               ram_rd_data,
  output logic                           ram_wr_en,
  output logic [SLOT_W-1:0]              ram_wr_addr,
  output ckat_pkg::entry_t               ram_wr_data,
  input  logic                           out_can_take,
  output logic                           out_push,
  output ckat_pkg::res_t                 out_res
);
  import ckat_pkg::*;

  localparam int PTR_W = $clog2(TABLE_SLOTS + 1);
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
  localparam logic [PTR_W-1:0] PTR_END = PTR_W'(TABLE_SLOTS);

  state_t state, state_next;

  logic [TABLE_SLOTS-1:0] slot_valid;
  op_t                    op_q;
  logic [IP_W-1:0]        ip_q;
  logic [PTR_W-1:0]       ptr;
  logic                   s1_valid;
  logic [SLOT_W-1:0]      s1_slot;
  logic                   hit;
  logic [SLOT_W-1:0]      hit_slot;
  logic                   free_found;
  logic [SLOT_W-1:0]      free_slot;
  logic [CNT_W-1:0]       evict_cnt;
  logic                   pend_valid;
  logic [IP_W-1:0]        pend_ip;

  logic                   accept;
  logic                   s1_live;
  logic                   match;
  logic                   scan_end;
  logic                   stall;
  logic                   advance;
  logic [AGE_W-1:0]       age_sum;
  logic [AGE_W-1:0]       age_start;
  logic                   evict;
  logic [CNT_W+EVICT_W-1:0] cnt_ext;
  logic                   add_insert;

  assign accept    = in_valid && in_ready;
  assign s1_live   = s1_valid && slot_valid[s1_slot];
  assign match     = s1_live && (ram_rd_data.ip == ip_q);
  assign scan_end  = (ptr == PTR_END) && !s1_valid;
  // a drain beat goes out only when the previous found address is pending
  assign stall     = (op_q == OP_DRAIN) && s1_live && pend_valid && !out_can_take;
  assign advance   = (state == ST_SCAN) && !stall && !scan_end;
  assign age_sum   = ram_rd_data.age + {2'b00, age_interval};
  assign age_start = '0 - {2'b00, age_interval};
  assign evict     = $signed(age_sum) > $signed({2'b00, age_timeout});
  assign cnt_ext   = (CNT_W+EVICT_W)'(evict_cnt);
  assign add_insert = !hit && free_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = ptr[SLOT_W-1:0];
    ram_wr_en   = 1'b0;
    ram_wr_addr = s1_slot;
    ram_wr_data = '{ip: ram_rd_data.ip, age: age_sum};
    out_push    = 1'b0;
    out_res     = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ram_rd_en = advance && (ptr != PTR_END);
        if (op_q == OP_TICK) begin
          ram_wr_en = advance && s1_live;
        end
        if (op_q == OP_DRAIN) begin
          out_push = advance && s1_live && pend_valid;
          out_res.done_flag  = 1'b1;
          out_res.drained_ip = pend_ip;
        end
        if (scan_end) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        out_push     = out_can_take;
        out_res.last = 1'b1;
        unique case (op_q)
          OP_ADD: begin
            out_res.done_flag  = add_insert;
            out_res.table_full = !hit && !free_found;
            ram_wr_en   = out_can_take && (hit || free_found);
            ram_wr_addr = hit ? hit_slot : free_slot;
            ram_wr_data = '{ip: ip_q, age: age_start};
          end
          OP_DELETE: begin
            out_res.done_flag = hit;
          end
          OP_TICK: begin
            out_res.evicted_count = cnt_ext[EVICT_W-1:0];
          end
          OP_DRAIN: begin
            out_res.done_flag  = pend_valid;
            out_res.drained_ip = pend_valid ? pend_ip : '0;
          end
          default: begin
          end
        endcase
        if (out_can_take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      s1_valid   <= 1'b0;
      pend_valid <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      evict_cnt  <= '0;
      ptr        <= '0;
    end else begin
      if (accept) begin
        op_q       <= in_op;
        ip_q       <= in_ip;
        ptr        <= '0;
        s1_valid   <= 1'b0;
        hit        <= 1'b0;
        free_found <= 1'b0;
        evict_cnt  <= '0;
        pend_valid <= 1'b0;
      end
      if (advance) begin
        if (ptr != PTR_END) begin
          ptr <= ptr + PTR_W'(1);
        end
        s1_valid <= ram_rd_en;
        s1_slot  <= ptr[SLOT_W-1:0];
        case (op_q)
          OP_ADD: begin
            if (match) begin
              hit      <= 1'b1;
              hit_slot <= s1_slot;
            end
            // remember the lowest free slot
            if (s1_valid && !slot_valid[s1_slot] && !free_found) begin
              free_found <= 1'b1;
              free_slot  <= s1_slot;
            end
          end
          OP_DELETE: begin
            if (match) begin
              hit                 <= 1'b1;
              slot_valid[s1_slot] <= 1'b0;
            end
          end
          OP_TICK: begin
            if (s1_live && evict) begin
              slot_valid[s1_slot] <= 1'b0;
              evict_cnt           <= evict_cnt + CNT_W'(1);
            end
          end
          default: begin
            // drain: hold one address back so the final beat can carry last
            if (s1_live) begin
              slot_valid[s1_slot] <= 1'b0;
              pend_ip             <= ram_rd_data.ip;
              pend_valid          <= 1'b1;
            end
          end
        endcase
      end
      if ((state == ST_FINISH) && out_can_take && (op_q == OP_ADD) && add_insert) begin
        slot_valid[free_slot] <= 1'b1;
      end
    end
  end

endmodule

// ----- sv/client_keepalive_aging_table.sv -----
// ----------------------------------------------------------------------------
// client_keepalive_aging_table
// Table of client addresses with per-entry aging, add/delete/tick/drain.
// ----------------------------------------------------------------------------
// Each input beat is one operation and is handled alone: the engine sweeps
// the entry memory one slot per cycle through its single read port and
// takes no new operation until the previous one has finished. A drain
// takes the same sweep and emits one beat per stored address in slot
// order, the last one flagged with tlast; downstream backpressure stretches
// the sweep. An empty drain gives a single all-zero beat with tlast. The
// result register lets the next operation be accepted while the final
// beat of the previous one still waits.
// ----------------------------------------------------------------------------
module client_keepalive_aging_table #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // config write port
  input  logic                              cfg_we,
  input  logic [ckat_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [ckat_pkg::CFG_W-1:0]        cfg_data,
  // operation stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [31:0]                       s_tdata,   // [31:0] client_ip
  input  logic [1:0]                        s_tuser,   // [1:0] operation
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] done_flag, [1] table_full, [33:2] drained_ip, [38:34] evicted_count,
  // [39] zero
  output logic [39:0]                       m_tdata,
  output logic                              m_tlast
);
  import ckat_pkg::*;

  localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  logic [CFG_W-1:0]  age_interval;
  logic [CFG_W-1:0]  age_timeout;

  logic              ram_rd_en;
  logic [SLOT_W-1:0] ram_rd_addr;
  entry_t            ram_rd_data;
  logic              ram_wr_en;
  logic [SLOT_W-1:0] ram_wr_addr;
  entry_t            ram_wr_data;

  logic              out_can_take;
  logic              out_push;
  res_t              out_res;
  res_t              m_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      age_interval <= CFG_W'(1);
      age_timeout  <= CFG_W'(3);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_AGE_INTERVAL: age_interval <= cfg_data;
        REG_AGE_TIMEOUT:  age_timeout  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ckat_entry_ram #(
    .DEPTH  (TABLE_SLOTS),
    .ADDR_W (SLOT_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data)
  );

  ckat_engine #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .SLOT_W      (SLOT_W)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_op        (op_t'(s_tuser)),
    .in_ip        (s_tdata),
    .age_interval (age_interval),
    .age_timeout  (age_timeout),
    .ram_rd_en    (ram_rd_en),
    .ram_rd_addr  (ram_rd_addr),
    .ram_rd_data  (ram_rd_data),
    .ram_wr_en    (ram_wr_en),
    .ram_wr_addr  (ram_wr_addr),
    .ram_wr_data  (ram_wr_data),
    .out_can_take (out_can_take),
    .out_push     (out_push),
    .out_res      (out_res)
  );

  ckat_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (out_push),
    .push_res (out_res),
    .can_take (out_can_take),
    .m_valid  (m_tvalid),
    .m_ready  (m_tready),
    .m_res    (m_res)
  );

  assign m_tdata = {1'b0, m_res.evicted_count, m_res.drained_ip,
                    m_res.table_full, m_res.done_flag};
  assign m_tlast = m_res.last;

  // one operation at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("operation accepted while previous one in progress");

  // only drain beats come without tlast, and each carries an address
  a_mid_beat_is_drain: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[0] && !m_tdata[1] && (m_tdata[38:34] == 5'd0))
    else $error("non-final beat that is not a drained entry");

  // an add cannot both insert and report a full table
  a_full_excl_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("done_flag and table_full both set");

endmodule
